>>> sv/depi_pkg.sv
// Package for the power-iteration eigenvector block.
// Holds widths, limits and shared types; no dependencies.
package depi_pkg;
    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int ACC_W     = 48;

    localparam logic [0:0] CFG_ITERATIONS  = 1'd0;
    localparam logic [0:0] CFG_SIZE_IN_USE = 1'd1;

    typedef enum logic [2:0] {
        ST_LOAD, ST_MAC, ST_MAX, ST_DIV, ST_NORM, ST_EMIT
    } t_state;

    // cell control: shift the row of cells, load a new value into cell 0
    typedef struct packed {
        logic        shift;
        logic        load;
        logic [31:0] din;
    } t_cell_ctl;
endpackage

>>> sv/depi_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module depi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/depi_cell.sv
// One vector cell: holds an element, passes it to the next cell on shift.
// Depends on depi_pkg.
module depi_cell (
    input  logic                 i_clk,
    input  depi_pkg::t_cell_ctl  i_ctl,
    input  logic [31:0]          i_prev,
    output logic [31:0]          o_val
);
    import depi_pkg::*;
    logic [31:0] r_val;
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) r_val <= i_ctl.load ? i_ctl.din : i_prev;
    end
    assign o_val = r_val;
endmodule

>>> sv/dominant_eigenvector_power_iteration_unit.sv
// Top level of the power-iteration eigenvector block.
// Depends on depi_pkg, depi_ram, depi_cell.
//
// Load n*n Q16.16 elements row-major, one item per accepted handshake. After the
// last element the block runs `iterations` rounds with one shared multiply-accumulate
// unit, then emits n result items (value, row index, last flag, zero-max flag).
// Two rings of n cells carry the vectors: the estimate ring rotates once per row
// so each cell presents its element to the MAC in turn; the product ring receives
// each finished row sum. Per round: a RAM read step, then an accumulate step, for
// every element; a max scan over the row sums; a bit-serial reciprocal of the
// maximum (cut short when the maximum is zero); and normalization with a multiply
// step and a write step per element. The n result items follow at one per cycle
// while the receiver is ready.
// Input is not accepted while a run is busy.
module dominant_eigenvector_power_iteration_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_elem,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_vec_value,
    output logic [2:0]  o_vec_index,
    output logic        o_last_item,
    output logic        o_div_zero
);
    import depi_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    t_state r_state, n_state;
    logic [7:0]  r_iter;
    logic [3:0]  r_size;
    logic [ADDR_W:0] r_load;
    logic [IDX_W-1:0] r_row, r_col;
    logic        r_rd_valid;      // RAM data for r_col is present
    logic [7:0]  r_round;
    logic        r_fault;
    logic signed [ACC_W-1:0] r_acc;
    logic [31:0] r_max;
    logic [5:0]  r_dcnt;
    logic [63:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_recip;
    logic        r_nphase;        // norm: 0 = multiply, 1 = write
    logic [63:0] r_nprod;
    logic        r_nneg;

    // effective size
    logic [IDX_W:0] w_n;
    always_comb begin
        if (r_size == 4'd0) w_n = (IDX_W+1)'(1);
        else if ({1'b0, r_size} > 5'(MAX_DIM)) w_n = (IDX_W+1)'(MAX_DIM);
        else w_n = (IDX_W+1)'(r_size);
    end
    logic [IDX_W-1:0] w_nm1;
    assign w_nm1 = IDX_W'(w_n - 1'b1);
    logic [ADDR_W:0] w_nn;
    assign w_nn = (ADDR_W+1)'(w_n * w_n);

    // matrix RAM
    logic [ADDR_W-1:0] w_raddr;
    logic [31:0] w_rdata;
    assign w_raddr = ADDR_W'(r_row * w_n + r_col);
    depi_ram #(.WIDTH(32), .DEPTH(MAX_DIM*MAX_DIM)) u_mat (
        .i_clk(i_clk), .i_we(i_valid && o_ready), .i_waddr(r_load[ADDR_W-1:0]),
        .i_wdata(i_elem), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // cell rings
    t_cell_ctl w_est_ctl, w_prd_ctl;
    logic [31:0] w_est [MAX_DIM];
    logic [31:0] w_prd [MAX_DIM];
    logic [31:0] w_est_head, w_prd_head;
    assign w_est_head = w_est[w_nm1];
    assign w_prd_head = w_prd[w_nm1];
    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++) begin : g_cells
            logic [31:0] w_pe, w_pp;
            if (g == 0) begin : g_first
                assign w_pe = w_est_head;
                assign w_pp = w_prd_head;
            end else begin : g_rest
                assign w_pe = w_est[g-1];
                assign w_pp = w_prd[g-1];
            end
            t_cell_ctl w_ec, w_pc;
            always_comb begin
                w_ec = w_est_ctl; w_pc = w_prd_ctl;
                w_ec.load = w_est_ctl.load && (g == 0);
                w_pc.load = w_prd_ctl.load && (g == 0);
            end
            depi_cell u_est (.i_clk(i_clk), .i_ctl(w_ec), .i_prev(w_pe), .o_val(w_est[g]));
            depi_cell u_prd (.i_clk(i_clk), .i_ctl(w_pc), .i_prev(w_pp), .o_val(w_prd[g]));
        end
    endgenerate

    // MAC operand: head of estimate ring (ring order: head = column r_col)
    logic signed [63:0] w_mprod;
    logic signed [ACC_W-1:0] w_term, w_acc_next;
    logic signed [ACC_W:0] w_sum;
    assign w_mprod = $signed(w_rdata) * $signed(w_est_head);
    always_comb begin
        if (r_round == 8'd0) w_term = ACC_W'($signed(w_rdata));
        else w_term = ACC_W'(w_mprod >>> FRAC_BITS);
        w_sum = {r_acc[ACC_W-1], r_acc} + {w_term[ACC_W-1], w_term};
        if (w_sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) w_acc_next = ACC_MAX;
        else if (w_sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) w_acc_next = ACC_MIN;
        else w_acc_next = w_sum[ACC_W-1:0];
    end
    logic [31:0] w_sat32;
    always_comb begin
        if (w_acc_next > 48'sh00007FFFFFFF) w_sat32 = 32'h7FFFFFFF;
        else if (w_acc_next < -48'sh000080000000) w_sat32 = 32'h80000000;
        else w_sat32 = w_acc_next[31:0];
    end

    logic [31:0] w_habs;
    assign w_habs = w_prd_head[31] ? 32'(-w_prd_head) : w_prd_head;

    logic w_last_row, w_last_col, w_last_round, w_out_fire;
    assign w_last_row = (r_row == w_nm1);
    assign w_last_col = (r_col == w_nm1);
    assign w_last_round = ({1'b0, r_round} + 9'd1 >= {1'b0, (r_iter == 8'd0 ? 8'd1 : r_iter)});
    assign w_out_fire = o_valid && i_ready;

    // reciprocal subtract step
    logic [64:0] w_rtry;
    logic [63:0] w_rsh;
    assign w_rsh = {r_rem[62:0], (r_dcnt == 6'd32)};
    assign w_rtry = {1'b0, w_rsh} - {33'd0, r_max};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (i_valid && (r_load + 1'b1 >= w_nn)) n_state = ST_MAC;
            ST_MAC:  if (r_rd_valid && w_last_col && w_last_row) n_state = ST_MAX;
            ST_MAX:  if (w_last_row) n_state = ST_DIV;
            ST_DIV:  if (r_max == 32'd0 || r_dcnt == 6'd0) n_state = ST_NORM;
            ST_NORM: if (r_nphase && w_last_row) n_state = w_last_round ? ST_EMIT : ST_MAC;
            ST_EMIT: if (w_out_fire && w_last_row) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    logic [63:0] w_nq;
    logic [31:0] w_nval;
    assign w_nq = r_nprod >> FRAC_BITS;
    always_comb begin
        if (r_max == 32'd0) w_nval = 32'd0;
        else if (w_nq > 64'h7FFFFFFF) w_nval = r_nneg ? 32'h80000000 : 32'h7FFFFFFF;
        else w_nval = r_nneg ? 32'(-w_nq[31:0]) : w_nq[31:0];
    end
    always_comb begin
        o_ready = (r_state == ST_LOAD);
        o_valid = (r_state == ST_EMIT);
        o_vec_value = w_est_head;
        o_vec_index = 3'(r_row);
        o_last_item = w_last_row;
        o_div_zero = r_fault;
        w_est_ctl = '{shift: 1'b0, load: 1'b0, din: w_nval};
        w_prd_ctl = '{shift: 1'b0, load: 1'b1, din: w_sat32};
        case (r_state)
            ST_MAC:  begin
                w_est_ctl.shift = r_rd_valid;
                w_prd_ctl.shift = r_rd_valid && w_last_col;
            end
            ST_MAX:  begin w_prd_ctl.shift = 1'b1; w_prd_ctl.load = 1'b0; end
            ST_NORM: begin
                w_prd_ctl.shift = !r_nphase; w_prd_ctl.load = 1'b0;
                w_est_ctl.shift = r_nphase; w_est_ctl.load = 1'b1;
            end
            ST_EMIT: w_est_ctl.shift = w_out_fire;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_iter <= 8'd10; r_size <= 4'd8; r_load <= '0;
            r_row <= '0; r_col <= '0; r_rd_valid <= 1'b0; r_round <= '0;
            r_fault <= 1'b0; r_acc <= '0; r_nphase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == CFG_ITERATIONS) r_iter <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_SIZE_IN_USE) begin
                r_size <= i_cfg_data[3:0]; r_load <= '0;
            end
            case (r_state)
                ST_LOAD: if (i_valid) begin
                    if (r_load + 1'b1 >= w_nn) begin
                        r_load <= '0; r_round <= '0; r_fault <= 1'b0;
                        r_row <= '0; r_col <= '0; r_rd_valid <= 1'b0; r_acc <= '0;
                    end else r_load <= r_load + 1'b1;
                end
                ST_MAC: begin
                    if (!r_rd_valid) r_rd_valid <= 1'b1;
                    else begin
                        r_rd_valid <= 1'b0;
                        if (w_last_col) begin
                            r_acc <= '0; r_col <= '0;
                            r_row <= w_last_row ? '0 : r_row + 1'b1;
                            r_max <= '0;
                        end else begin
                            r_acc <= w_acc_next; r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_MAX: begin
                    if (w_habs > r_max) r_max <= w_habs;
                    r_row <= w_last_row ? '0 : r_row + 1'b1;
                    r_dcnt <= 6'd32; r_rem <= '0; r_quo <= '0;
                end
                ST_DIV: begin
                    if (r_max == 32'd0) r_fault <= 1'b1;
                    if (w_rtry[64]) begin r_rem <= w_rsh; r_quo <= {r_quo[30:0], 1'b0}; end
                    else begin r_rem <= w_rtry[63:0]; r_quo <= {r_quo[30:0], 1'b1}; end
                    if (r_dcnt != 6'd0) r_dcnt <= r_dcnt - 1'b1;
                    // 2^32 / max exceeds 2^31-1 for max of 1 or 2; saturate
                    if (r_dcnt == 6'd0 || r_max == 32'd0)
                        r_recip <= (r_max <= 32'd2) ? 32'h7FFFFFFF
                                   : (w_rtry[64] ? {r_quo[30:0], 1'b0} : {r_quo[30:0], 1'b1});
                    r_nphase <= 1'b0;
                end
                ST_NORM: begin
                    r_nphase <= !r_nphase;
                    if (!r_nphase) begin
                        r_nprod <= w_habs * r_recip;
                        r_nneg <= w_prd_head[31];
                    end else begin
                        r_row <= w_last_row ? '0 : r_row + 1'b1;
                        if (w_last_row) r_round <= r_round + 1'b1;
                    end
                end
                ST_EMIT: if (w_out_fire) r_row <= w_last_row ? '0 : r_row + 1'b1;
                default: ;
            endcase
        end
    end
endmodule

>>> tb/depi_checker.sv
// Checker for the power-iteration eigenvector block: predicts result items
// from accepted matrix elements and register writes, compares them. Uses depi_pkg.
`timescale 1ns / 1ps
module depi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [31:0] i_elem,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_vec_value,
    input  logic [2:0]         i_vec_index,
    input  logic               i_last_item,
    input  logic               i_div_zero,
    output int                 o_fail_count,
    output int                 o_pending
);
    import depi_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         index;
        logic               last;
        logic               dz;
    } t_vec_item;

    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint W_HI   = 64'sh7FFF_FFFF;
    localparam longint W_LO   = -W_HI - 1;

    t_vec_item    vec_q[$];
    logic [7:0]   rounds_reg;
    logic [3:0]   size_reg;
    int           fill;
    logic signed [31:0] mat[MAX_DIM*MAX_DIM];
    logic signed [31:0] est[MAX_DIM];
    logic signed [31:0] prod[MAX_DIM];
    logic         zero_max;

    function automatic int eff_dim();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_DIM) return MAX_DIM;
        return size_reg;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic scale_by_max(int n);
        longint unsigned peak, recip, m;
        longint q;
        peak = 0;
        for (int i = 0; i < n; i++) begin
            m = prod[i] < 0 ? -longint'(prod[i]) : longint'(prod[i]);
            if (m > peak) peak = m;
        end
        if (peak == 0) begin
            zero_max = 1'b1;
            for (int i = 0; i < n; i++) est[i] = 0;
            return;
        end
        recip = (64'd1 << (2 * FRAC_BITS)) / peak;
        if (recip > 64'h7FFF_FFFF) recip = 64'h7FFF_FFFF;
        for (int i = 0; i < n; i++) begin
            m = prod[i] < 0 ? -longint'(prod[i]) : longint'(prod[i]);
            q = longint'((m * recip) >> FRAC_BITS);
            if (prod[i] < 0) q = -q;
            est[i] = 32'(clip(q, W_LO, W_HI));
        end
    endtask

    // full power iteration on the loaded matrix, then queue n result items
    task automatic iterate_and_queue(int n);
        longint acc, p;
        int rounds;
        t_vec_item it;
        rounds = rounds_reg == 0 ? 1 : rounds_reg;
        zero_max = 1'b0;
        for (int r = 0; r < rounds; r++) begin
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    if (r == 0) p = mat[i*n+k];
                    else p = (longint'(mat[i*n+k]) * longint'(est[k])) >>> FRAC_BITS;
                    acc = clip(acc + p, ACC_LO, ACC_HI);
                end
                prod[i] = 32'(clip(acc, W_LO, W_HI));
            end
            scale_by_max(n);
        end
        for (int i = 0; i < n; i++) begin
            it.value = est[i];
            it.index = 3'(i);
            it.last  = (i == n - 1);
            it.dz    = zero_max;
            vec_q.push_back(it);
        end
    endtask

    task automatic report(string field, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_vec_item w;
        int n;
        if (!i_rst_n) begin
            rounds_reg   = 8'd10;
            size_reg     = 4'd8;
            fill         = 0;
            o_fail_count = 0;
            vec_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ITERATIONS) rounds_reg = i_cfg_data;
                else if (i_cfg_index == CFG_SIZE_IN_USE) begin
                    size_reg = i_cfg_data[3:0];
                    fill = 0;
                end
            end
            if (i_valid && i_ready_in) begin
                n = eff_dim();
                if (fill >= n * n) fill = 0;
                mat[fill] = i_elem;
                fill++;
                if (fill == n * n) begin
                    fill = 0;
                    iterate_and_queue(n);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (vec_q.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    w = vec_q.pop_front();
                    if (i_vec_value !== w.value) report("vec_value", w.value, i_vec_value);
                    if (i_vec_index !== w.index) report("vec_index", w.index, i_vec_index);
                    if (i_last_item !== w.last)  report("last_item", w.last, i_last_item);
                    if (i_div_zero !== w.dz)     report("div_zero", w.dz, i_div_zero);
                end
            end
        end
        o_pending = vec_q.size();
    end
endmodule

>>> tb/testbench.sv
// Top of the testbench for the power-iteration eigenvector block.
// Drives matrices and register writes; depi_checker does prediction. Uses depi_pkg.
`timescale 1ns / 1ps
module testbench;
    import depi_pkg::*;

    logic               i_clk, i_rst_n;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;
    logic               i_valid, o_ready;
    logic signed [31:0] i_elem;
    logic               o_valid;
    logic               i_ready = 1'b1;
    logic signed [31:0] o_vec_value;
    logic [2:0]         o_vec_index;
    logic               o_last_item, o_div_zero;
    int                 fail_count, pending;

    int burst_left;       // items left in the current sender burst
    int stall_mode = 0;   // receiver behavior, changes now and then
    int n_items;

    dominant_eigenvector_power_iteration_unit dut (.*);

    depi_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_elem(i_elem),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_vec_value(o_vec_value), .i_vec_index(o_vec_index),
        .i_last_item(o_last_item), .i_div_zero(o_div_zero),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: always ready, coin flip, or long stalls
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            default: i_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // one item; called and left at a falling edge, valid stays high afterwards
    task automatic send_elem(logic signed [31:0] v);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_elem  <= v;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
        @(negedge i_clk);
    endtask

    // drop valid, wait for every pending result, let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random element: mostly small well-conditioned values, sometimes any 32 bits
    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2:    return 32'sh0;
            default: return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        endcase
    endfunction

    task automatic send_matrix(int n);
        for (int k = 0; k < n * n; k++) send_elem(rand_elem());
    endtask

    int n, it;

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_elem = '0;
        burst_left = 0; n_items = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: 2x2 extremes, one round
        write_reg(CFG_ITERATIONS, 8'd1);
        write_reg(CFG_SIZE_IN_USE, 8'd2);
        send_elem(32'sh7FFF_FFFF); send_elem(32'sh7FFF_FFFF);
        send_elem(-32'sh8000_0000); send_elem(-32'sh8000_0000);
        // all-zero matrix: zero maximum flag
        repeat (4) send_elem(32'sh0);
        // the largest round count on the same size
        write_reg(CFG_ITERATIONS, 8'd255);
        send_elem(32'sh2_0000); send_elem(32'sh1_0000);
        send_elem(32'sh1_0000); send_elem(-32'sh3_0000);
        // zero size acts as one, zero rounds acts as one
        write_reg(CFG_ITERATIONS, 8'd0);
        write_reg(CFG_SIZE_IN_USE, 8'd0);
        send_elem(-32'sh1); send_elem(32'sh1);
        // size rewritten mid-load restarts the load
        write_reg(CFG_SIZE_IN_USE, 8'd2);
        send_elem(32'sh5_0000); send_elem(32'sh7_0000);
        write_reg(CFG_SIZE_IN_USE, 8'd2);
        send_elem(32'sh0); send_elem(32'sh0); send_elem(32'sh0); send_elem(32'sh0);
        // oversize acts as the built maximum
        write_reg(CFG_ITERATIONS, 8'd3);
        write_reg(CFG_SIZE_IN_USE, 8'd15);
        send_matrix(MAX_DIM);

        // random phases
        while (n_items < 200) begin
            case ($urandom_range(0, 9))
                0:       n = MAX_DIM;
                1:       n = $urandom_range(9, 15);
                default: n = $urandom_range(1, 4);
            endcase
            it = (n <= 2 && $urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 16);
            write_reg(CFG_ITERATIONS, 8'(it));
            write_reg(CFG_SIZE_IN_USE, 8'(n));
            if (n > MAX_DIM) n = MAX_DIM;
            if ($urandom_range(0, 7) == 0) begin
                // broken sequence: up to n*n elements, then a size write abandons any partial load
                for (int k = 0; k < $urandom_range(1, n * n); k++) send_elem(rand_elem());
                write_reg(CFG_SIZE_IN_USE, 8'(n));
            end
            for (int m = 0; m < $urandom_range(1, 3); m++) begin
                if ($urandom_range(0, 3) == 0) drain();  // hold off until all results are in
                send_matrix(n);
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

>>> files.f
sv/depi_pkg.sv
sv/depi_ram.sv
sv/depi_cell.sv
sv/dominant_eigenvector_power_iteration_unit.sv
tb/depi_checker.sv
tb/testbench.sv
